### hw/rtl/itoa_pkg.sv
// Shared types, codes and character helpers for the integer to ASCII converter.
package itoa_pkg;

  // Format codes carried on the command field; code three prints as unsigned decimal.
  localparam logic [1:0] CMD_SIGNED   = 2'd0;
  localparam logic [1:0] CMD_UNSIGNED = 2'd1;
  localparam logic [1:0] CMD_HEX      = 2'd2;

  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     dec;
  } cell_ctrl_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

### hw/rtl/itoa_if.sv
// Valid/ready channel interfaces for the converter's input words and output characters.
interface itoa_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [1:0]             command;

  modport source (output valid, output value, output command, input ready);
  modport sink   (input valid, input value, input command, output ready);
endinterface

interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

### hw/rtl/itoa_cell.sv
// One digit cell: shift-and-add-3 binary to BCD step, plain nibble shift, digit move, hold or clear.
module itoa_cell (
  input  logic                 clk,
  input  itoa_pkg::cell_ctrl_t ctrl,
  input  logic                 bit_in,
  input  logic [3:0]           digit_in,
  output logic [3:0]           digit_out,
  output logic                 carry_out
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] corrected;

  // decimal: pre-correct so the doubled digit carries at ten
  assign corrected = (ctrl.dec && (digit_r >= 4'd5)) ? (digit_r + 4'd3) : digit_r;
  assign carry_out = corrected[3];
  assign digit_out = digit_r;

  always_comb begin
    case (ctrl.op)
      itoa_pkg::CELL_HOLD:   digit_nxt = digit_r;
      itoa_pkg::CELL_CLEAR:  digit_nxt = 4'd0;
      itoa_pkg::CELL_DABBLE: digit_nxt = {corrected[2:0], bit_in};
      itoa_pkg::CELL_SHIFT:  digit_nxt = digit_in;
      default:               digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

### hw/rtl/integer_to_ascii_converter.sv
// Top level: integer to ASCII converter built on a chain of BCD/hex digit cells.
//
//   channel   dir  beat payload                       handshake
//   in_bus    in   value[VALUE_WIDTH-1:0], command    valid/ready
//   out_bus   out  character[6:0], last               valid/ready
//
// Steps: the idle state takes the word, ST_CONV shifts its bits one by one through the cells
// (add-3 correction for decimal, plain shift for hex), ST_STRIP drops the leading zero
// digits, then ST_EMIT sends '-' and the digits one per cycle while out_bus is ready.
// Reset (rst_n low, synchronous) returns to idle and drops any pending beat. A stalled
// out_bus holds the character register; the next word is taken while the last one waits.
module integer_to_ascii_converter #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  itoa_in_if.sink        in_bus,
  itoa_out_if.source     out_bus
);

  // digit cells: enough for the decimal or the hex form of the widest word
  localparam int DecDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int HexDigits = (VALUE_WIDTH + 3) / 4;
  localparam int NumCells  = (DecDigits > HexDigits) ? DecDigits : HexDigits;
  localparam int CntW      = $clog2(NumCells + 1);
  localparam int BitCntW   = $clog2(VALUE_WIDTH);

  itoa_pkg::state_t state_r, state_nxt;

  logic [VALUE_WIDTH-1:0] sr_r, sr_nxt;
  logic [BitCntW-1:0]     bitcnt_r, bitcnt_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   dec_r, dec_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [6:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_fire;
  logic                   out_load;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   top_zero;
  logic                   last_digit;
  itoa_pkg::cell_op_t     cell_op;
  itoa_pkg::cell_ctrl_t   cell_ctrl;

  logic [3:0] digit [NumCells];
  logic       carry [NumCells];

  assign in_fire    = in_bus.valid && in_bus.ready;
  assign neg_in     = (in_bus.command == itoa_pkg::CMD_SIGNED) && in_bus.value[VALUE_WIDTH-1];
  assign mag_in     = neg_in ? VALUE_WIDTH'(~in_bus.value + 1'b1) : in_bus.value;
  assign top_zero   = (digit[NumCells-1] == 4'd0);
  assign last_digit = (cnt_r == CntW'(1));
  assign cell_ctrl  = '{op: cell_op, dec: dec_r};

  // ---------------- digit cell chain ----------------
  // dabble: bits ripple up from the word's MSB; shift: digits move toward the top cell
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = sr_r[VALUE_WIDTH-1];
      assign digit_in = 4'd0;
    end else begin : g_rest
      assign bit_in   = carry[i-1];
      assign digit_in = digit[i-1];
    end
    itoa_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .bit_in    (bit_in),
      .digit_in  (digit_in),
      .digit_out (digit[i]),
      .carry_out (carry[i])
    );
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = itoa_pkg::ST_CONV;
      end
      itoa_pkg::ST_CONV: begin
        if (bitcnt_r == '0) state_nxt = itoa_pkg::ST_STRIP;
      end
      itoa_pkg::ST_STRIP: begin
        if (!top_zero || last_digit) state_nxt = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (out_load && !neg_r && last_digit) state_nxt = itoa_pkg::ST_IDLE;
      end
      default: state_nxt = itoa_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    in_bus.ready = 1'b0;
    out_load     = 1'b0;
    cell_op      = itoa_pkg::CELL_HOLD;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_fire) cell_op = itoa_pkg::CELL_CLEAR;
      end
      itoa_pkg::ST_CONV: begin
        cell_op = itoa_pkg::CELL_DABBLE;
      end
      itoa_pkg::ST_STRIP: begin
        if (top_zero && !last_digit) cell_op = itoa_pkg::CELL_SHIFT;
      end
      itoa_pkg::ST_EMIT: begin
        out_load = !out_valid_r || out_bus.ready;
        if (out_load && !neg_r) cell_op = itoa_pkg::CELL_SHIFT;
      end
      default: begin
        in_bus.ready = 1'b0;
      end
    endcase
  end

  // ---------------- datapath next values ----------------
  always_comb begin
    sr_nxt        = sr_r;
    bitcnt_nxt    = bitcnt_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    dec_nxt       = dec_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (in_fire) begin
      sr_nxt     = mag_in;
      bitcnt_nxt = BitCntW'(VALUE_WIDTH - 1);
      cnt_nxt    = CntW'(NumCells);
      neg_nxt    = neg_in;
      dec_nxt    = (in_bus.command != itoa_pkg::CMD_HEX);
    end

    if (state_r == itoa_pkg::ST_CONV) begin
      sr_nxt     = {sr_r[VALUE_WIDTH-2:0], 1'b0};
      bitcnt_nxt = bitcnt_r - 1'b1;
    end

    if (cell_op == itoa_pkg::CELL_SHIFT && state_r == itoa_pkg::ST_STRIP) begin
      cnt_nxt = cnt_r - 1'b1;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (neg_r) begin
        out_char_nxt = itoa_pkg::CHAR_MINUS;
        out_last_nxt = 1'b0;
        neg_nxt      = 1'b0;
      end else begin
        out_char_nxt = itoa_pkg::digit_char(digit[NumCells-1]);
        out_last_nxt = last_digit;
        cnt_nxt      = cnt_r - 1'b1;
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sr_r       <= sr_nxt;
    bitcnt_r   <= bitcnt_nxt;
    dec_r      <= dec_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.character = out_char_r;
  assign out_bus.last      = out_last_r;

  // ---------------- assertions ----------------
  // an accepted word always starts the bit-serial conversion
  a_accept_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == itoa_pkg::ST_CONV))
    else $error("accepted word did not start conversion");

  // conversion ends after the last of the VALUE_WIDTH bits, then leading zeros are stripped
  a_conv_to_strip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itoa_pkg::ST_CONV) && (bitcnt_r == '0) |=> (state_r == itoa_pkg::ST_STRIP))
    else $error("conversion did not end after the last bit");

  // at least one digit remains while stripping or sending
  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itoa_pkg::ST_STRIP) || (state_r == itoa_pkg::ST_EMIT) |-> (cnt_r != '0))
    else $error("digit count ran out before the last character");

endmodule
